// File: hdl/hrfd_pkg.sv
// Shared types and constants for the HID report frame deframer.
// No dependencies; imported by every module of the block.
package hrfd_pkg;

  localparam int unsigned BUFFER_DEPTH = 128;  // 8..255, frame dropped at this byte count
  localparam int unsigned KEY_CAP      = 6;    // 1..6, keys taken from a keyboard frame
  localparam int unsigned HEAD_DEPTH   = 7;    // payload bytes kept per frame
  localparam int unsigned NUM_KEYS     = 6;    // key fields on the output
  localparam int unsigned QUEUE_DEPTH  = 2;    // power of two

  // configuration register indexes
  localparam logic [1:0] REG_SYNC  = 2'd0;
  localparam logic [1:0] REG_KBD   = 2'd1;
  localparam logic [1:0] REG_MOUSE = 2'd2;

  localparam logic [7:0] SYNC_RST  = 8'hA5;
  localparam logic [7:0] KBD_RST   = 8'd75;  // 'K'
  localparam logic [7:0] MOUSE_RST = 8'd77;  // 'M'

  // report kinds
  localparam logic KIND_KEYBOARD = 1'b0;
  localparam logic KIND_MOUSE    = 1'b1;

  typedef struct packed {
    logic                             kind;
    logic [7:0]                       len;
    logic [HEAD_DEPTH-1:0][7:0]       head;
  } hrfd_entry_t;

endpackage

// File: hdl/hrfd_parser.sv
// Front end: frame parser. Hunts sync, tracks type/length/checksum and
// pushes one entry per good keyboard or mouse frame. Uses hrfd_pkg.
module hrfd_parser
  import hrfd_pkg::*;
#(
  parameter int unsigned BufDepth = BUFFER_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  sync_i,
  input  logic [7:0]  kbd_type_i,
  input  logic [7:0]  mouse_type_i,
  input  logic        byte_valid_i,
  input  logic [7:0]  byte_i,
  output logic        push_o,
  output hrfd_entry_t entry_o
);

  logic [7:0]                 cnt_q, cnt_d;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 type_q, type_d;
  logic [7:0]                 len_q, len_d;
  logic [HEAD_DEPTH-1:0][7:0] head_q, head_d;
  logic [8:0]                 count;
  logic [8:0]                 expected;
  logic [7:0]                 sum_new;
  logic                       good;

  assign count    = {1'b0, cnt_q} + 9'd1;
  assign expected = {1'b0, len_q} + 9'd4;
  assign sum_new  = sum_q + byte_i;

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    type_d = type_q;
    len_d  = len_q;
    head_d = head_q;
    good   = 1'b0;
    if (byte_valid_i) begin
      if (cnt_q == 8'd0) begin
        if (byte_i == sync_i) begin
          cnt_d = 8'd1;
          sum_d = 8'd0;
        end
      end else begin
        cnt_d = count[7:0];
        sum_d = sum_new;
        if (cnt_q == 8'd1) begin
          type_d = byte_i;
        end else if (cnt_q == 8'd2) begin
          len_d = byte_i;
        end else begin
          for (int i = 0; i < HEAD_DEPTH; i++) begin
            if (cnt_q == 8'(i + 3)) head_d[i] = byte_i;
          end
        end
        if (count >= 9'd3) begin
          if (count == expected) begin
            if (sum_new != 8'd0) begin
              // bad checksum: a trailing sync byte reopens a frame
              if (byte_i == sync_i) begin
                cnt_d = 8'd1;
                sum_d = 8'd0;
              end else begin
                cnt_d = 8'd0;
              end
            end else begin
              cnt_d = 8'd0;
              good  = 1'b1;
            end
          end else if (count >= 9'(BufDepth)) begin
            cnt_d = 8'd0;
          end
        end
      end
    end
  end

  // keyboard type wins when both registers match
  always_comb begin
    entry_o.kind = (type_q == kbd_type_i) ? KIND_KEYBOARD : KIND_MOUSE;
    entry_o.len  = len_q;
    entry_o.head = head_q;
    push_o       = good && ((type_q == kbd_type_i) || (type_q == mouse_type_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      type_q <= '0;
      len_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      type_q <= type_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
  end

endmodule

// File: hdl/hrfd_queue.sv
// Short FIFO of decoded frames between parser and formatter.
// Uses hrfd_pkg for the entry type and depth.
module hrfd_queue
  import hrfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  hrfd_entry_t entry_i,
  output logic        full_o,
  output logic        nonempty_o,
  input  logic        pop_i,
  output hrfd_entry_t entry_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  hrfd_entry_t     mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [PW:0]     fill_q, fill_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (fill_q == (PW + 1)'(QUEUE_DEPTH));
  assign nonempty_o = (fill_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign entry_o    = mem_q[rd_q];

  always_comb begin
    wr_d   = do_push ? wr_q + 1'b1 : wr_q;
    rd_d   = do_pop ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (do_push && !do_pop) fill_d = fill_q + 1'b1;
    else if (do_pop && !do_push) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule

// File: hdl/hrfd_formatter.sv
// Back end: turns a decoded frame into a keyboard or mouse report and
// holds it in the output register. Uses hrfd_pkg.
module hrfd_formatter
  import hrfd_pkg::*;
#(
  parameter int unsigned KeyCap = KEY_CAP
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  hrfd_entry_t entry_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser
);

  logic                     vld_q;
  logic                     kind_q;
  logic [7:0]               mod_q, mod_d;
  logic [NUM_KEYS-1:0][7:0] keys_q, keys_d;
  logic [7:0]               mx_q, mx_d;
  logic [7:0]               my_q, my_d;
  logic                     load;

  assign load  = entry_valid_i && (!vld_q || m_axis_tready);
  assign pop_o = load;

  // bytes past the payload length read as zero
  always_comb begin
    mod_d  = (entry_i.len > 8'd0) ? entry_i.head[0] : 8'd0;
    keys_d = '0;
    mx_d   = 8'd0;
    my_d   = 8'd0;
    if (entry_i.kind == KIND_KEYBOARD) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (k < KeyCap && entry_i.len > 8'(k + 1)) keys_d[k] = entry_i.head[k + 1];
      end
    end else begin
      mx_d = (entry_i.len > 8'd1) ? entry_i.head[1] : 8'd0;
      my_d = (entry_i.len > 8'd2) ? entry_i.head[2] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= entry_i.kind;
      mod_q  <= mod_d;
      keys_q <= keys_d;
      mx_q   <= mx_d;
      my_q   <= my_d;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {my_q, mx_q, keys_q, mod_q};
  assign m_axis_tuser  = kind_q;

endmodule

// File: hdl/hid_report_frame_deframer_core.sv
// HID report frame deframer: takes one received byte per transfer and
// delivers one report per good keyboard or mouse frame. Frame layout is
// sync, type, length L, L payload bytes, checksum; the 8-bit sum of all
// bytes after sync must be zero. One byte is taken every clock cycle while
// the queue is not full; the parser registers count and running sum.
// Reports go through a two-entry queue to a registered output, so input
// stalls only when the queue is full. A report enters the queue on its
// checksum byte and then the output register. Frames are dropped at
// BufDepth bytes (128 by default); KeyCap limits the keys taken from a
// keyboard frame. Config writes take effect next cycle and are meant for
// idle time. Depends on hrfd_pkg, hrfd_parser, hrfd_queue, hrfd_formatter.
module hid_report_frame_deframer_core
  import hrfd_pkg::*;
#(
  parameter int unsigned BufDepth = BUFFER_DEPTH,
  parameter int unsigned KeyCap   = KEY_CAP
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] mod_or_buttons, [15:8]..[55:48] key_0..key_5,
  // [63:56] move_x, [71:64] move_y
  output logic [71:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser    // [0] report_kind
);

  logic [7:0]  sync_q;
  logic [7:0]  kbd_q;
  logic [7:0]  mouse_q;
  logic        q_full;
  logic        q_nonempty;
  logic        push;
  logic        pop;
  hrfd_entry_t push_entry;
  hrfd_entry_t pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= SYNC_RST;
      kbd_q   <= KBD_RST;
      mouse_q <= MOUSE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC:  sync_q  <= cfg_wdata_i;
        REG_KBD:   kbd_q   <= cfg_wdata_i;
        REG_MOUSE: mouse_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;

  hrfd_parser #(
    .BufDepth (BufDepth)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_i       (sync_q),
    .kbd_type_i   (kbd_q),
    .mouse_type_i (mouse_q),
    .byte_valid_i (s_axis_tvalid && s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  hrfd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (push_entry),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .pop_i      (pop),
    .entry_o    (pop_entry)
  );

  hrfd_formatter #(
    .KeyCap (KeyCap)
  ) u_formatter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_nonempty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
